// File: hw/rtl/cst_pkg.sv
// Shared types, character constants and byte classes for the C source tokenizer.
`default_nettype none

package cst_pkg;

    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_PIPE   = 8'h7c;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_BANG   = 8'h21;

    typedef enum logic [8:0] {
        MODE_IDLE    = 9'b000000001,
        MODE_WORD    = 9'b000000010,
        MODE_CHR     = 9'b000000100,
        MODE_CHR_ESC = 9'b000001000,
        MODE_STR     = 9'b000010000,
        MODE_STR_ESC = 9'b000100000,
        MODE_OP      = 9'b001000000,
        MODE_SHIFT   = 9'b010000000,
        MODE_ERROR   = 9'b100000000
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       lex_error;
        logic       text_done;
        logic       last_of_run;
    } out_rec_t;

    typedef struct packed {
        logic [1:0]          cnt;
        out_rec_t [2:0]      rec;
    } lex_res_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h61:8'h7a], [8'h41:8'h5a]}) ||
               (b == CH_UNDER) || (b == CH_DOLLAR);
    endfunction

    function automatic logic is_lone(input logic [7:0] b);
        return b inside {8'h28, 8'h29, 8'h3b, 8'h2c, 8'h7b, 8'h7d, 8'h5b, 8'h5d,
                         8'h7e, 8'h2e};
    endfunction

    function automatic logic is_op_start(input logic [7:0] b);
        return b inside {CH_EQ, CH_STAR, CH_PIPE, CH_CARET, CH_AMP, CH_LT, CH_GT,
                         CH_PLUS, CH_MINUS, CH_SLASH, CH_PCT, CH_BANG};
    endfunction

    function automatic logic op_follows(input logic [7:0] op, input logic [7:0] b);
        logic r;
        r = 1'b0;
        if (b == CH_EQ)
        begin
            r = 1'b1;
        end
        else if (op inside {CH_PIPE, CH_AMP, CH_LT, CH_GT, CH_PLUS})
        begin
            r = (b == op);
        end
        else if (op == CH_MINUS)
        begin
            r = (b == CH_MINUS) || (b == CH_GT);
        end
        return r;
    endfunction

    function automatic out_rec_t mk_rec(input logic [7:0] b, input logic v,
                                        input logic err);
        out_rec_t r;
        r.out_byte    = v ? b : 8'h00;
        r.byte_valid  = v;
        r.lex_error   = err;
        r.text_done   = 1'b0;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/c_source_tokenizer_core.sv
// Top level of the streaming C source tokenizer.
// Flow: an accepted byte waits in the input register until the result buffer is free;
// it is then decoded and its results are loaded into the buffer, which offers them.
// Throughput: one result byte per cycle while m_axis_tready is high; an item holds
// the decoder until its last result byte is taken, set by the single-byte result channel.
// Reset (rst_n low, asynchronous): lexer idle, no pending operator, buffers empty.
`default_nettype none

module c_source_tokenizer_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tlast,   // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte
    output logic [2:0]       m_axis_tuser,   // byte_valid, lex_error, text_done
    output logic             m_axis_tlast    // last_of_run
);
    import cst_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;
    logic       free;
    logic       fire;
    lex_res_t   res;

    assign fire          = in_vld_reg && free;
    assign s_axis_tready = !in_vld_reg || free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eot_reg  <= s_axis_tlast;
        end
    end

    cst_lex u_lex
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .in_eot  (in_eot_reg),
        .res     (res)
    );

    cst_obuf u_obuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .res           (res),
        .free          (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: hw/rtl/cst_lex.sv
// Lexer state and per-byte decode into up to three result bytes.
`default_nettype none

module cst_lex
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_eot,
    output cst_pkg::lex_res_t     res
);
    import cst_pkg::*;

    lex_mode_t  mode_reg;
    lex_mode_t  mode_next;
    logic [7:0] op_reg;
    logic [7:0] op_next;

    always_comb
    begin
        logic [1:0] n;
        logic       start;
        n         = 2'd0;
        start     = 1'b0;
        res       = '0;
        mode_next = mode_reg;
        op_next   = op_reg;

        if (in_eot)
        begin
            if (mode_reg == MODE_WORD || mode_reg == MODE_OP || mode_reg == MODE_SHIFT)
            begin
                res.rec[0] = mk_rec(CH_NL, 1'b1, 1'b0);
            end
            else
            begin
                res.rec[0] = mk_rec(8'h00, 1'b0, mode_reg == MODE_ERROR);
            end
            res.rec[0].text_done = 1'b1;
            n         = 2'd1;
            mode_next = MODE_IDLE;
            op_next   = 8'h00;
        end
        else
        begin
            case (mode_reg)
                MODE_ERROR:
                begin
                end
                MODE_CHR, MODE_STR:
                begin
                    res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                    n = n + 2'd1;
                    if (in_byte == ((mode_reg == MODE_CHR) ? CH_SQUOTE : CH_DQUOTE))
                    begin
                        res.rec[n] = mk_rec(CH_NL, 1'b1, 1'b0);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        mode_next = (mode_reg == MODE_CHR) ? MODE_CHR_ESC : MODE_STR_ESC;
                    end
                end
                MODE_CHR_ESC:
                begin
                    res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                    n = n + 2'd1;
                    mode_next = MODE_CHR;
                end
                MODE_STR_ESC:
                begin
                    res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                    n = n + 2'd1;
                    mode_next = MODE_STR;
                end
                MODE_WORD:
                begin
                    if (is_word(in_byte))
                    begin
                        res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        res.rec[n] = mk_rec(CH_NL, 1'b1, 1'b0);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                        start = 1'b1;
                    end
                end
                MODE_OP:
                begin
                    if (op_follows(op_reg, in_byte))
                    begin
                        res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                        n = n + 2'd1;
                        if ((op_reg == CH_LT || op_reg == CH_GT) && in_byte == op_reg)
                        begin
                            mode_next = MODE_SHIFT;
                        end
                        else
                        begin
                            res.rec[n] = mk_rec(CH_NL, 1'b1, 1'b0);
                            n = n + 2'd1;
                            mode_next = MODE_IDLE;
                            op_next   = 8'h00;
                        end
                    end
                    else
                    begin
                        res.rec[n] = mk_rec(CH_NL, 1'b1, 1'b0);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                        op_next   = 8'h00;
                        start     = 1'b1;
                    end
                end
                MODE_SHIFT:
                begin
                    mode_next = MODE_IDLE;
                    op_next   = 8'h00;
                    if (in_byte == CH_EQ)
                    begin
                        res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                        n = n + 2'd1;
                        res.rec[n] = mk_rec(CH_NL, 1'b1, 1'b0);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        res.rec[n] = mk_rec(CH_NL, 1'b1, 1'b0);
                        n = n + 2'd1;
                        start = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    op_next   = 8'h00;
                    start     = 1'b1;
                end
            endcase

            if (start && !is_space(in_byte))
            begin
                if (in_byte == CH_SQUOTE)
                begin
                    res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                    n = n + 2'd1;
                    mode_next = MODE_CHR;
                end
                else if (in_byte == CH_DQUOTE)
                begin
                    res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                    n = n + 2'd1;
                    mode_next = MODE_STR;
                end
                else if (is_word(in_byte))
                begin
                    res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                    n = n + 2'd1;
                    mode_next = MODE_WORD;
                end
                else if (is_op_start(in_byte))
                begin
                    res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                    n = n + 2'd1;
                    op_next   = in_byte;
                    mode_next = MODE_OP;
                end
                else if (is_lone(in_byte))
                begin
                    res.rec[n] = mk_rec(in_byte, 1'b1, 1'b0);
                    n = n + 2'd1;
                    res.rec[n] = mk_rec(CH_NL, 1'b1, 1'b0);
                    n = n + 2'd1;
                end
                else
                begin
                    mode_next = MODE_ERROR;
                    res.rec[n] = mk_rec(8'h00, 1'b0, 1'b1);
                    n = n + 2'd1;
                end
            end
        end

        if (n != 2'd0)
        begin
            res.rec[n - 2'd1].last_of_run = 1'b1;
        end
        res.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            op_reg   <= 8'h00;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            op_reg   <= op_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cst_obuf.sv
// Result buffer: holds the bytes of one decoded item and sends them one per request.
`default_nettype none

module cst_obuf
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire cst_pkg::lex_res_t res,
    output logic                  free,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // out_byte
    output logic [2:0]            m_axis_tuser,   // byte_valid, lex_error, text_done
    output logic                  m_axis_tlast    // last_of_run
);
    import cst_pkg::*;

    out_rec_t [2:0] ent_reg;
    logic [1:0]     cnt_reg;
    logic [1:0]     idx_reg;
    out_rec_t       cur;
    logic           pop;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = ent_reg[0];
            2'd1:    cur = ent_reg[1];
            default: cur = ent_reg[2];
        endcase
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = cur.out_byte;
    assign m_axis_tuser  = {cur.text_done, cur.lex_error, cur.byte_valid};
    assign m_axis_tlast  = cur.last_of_run;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign free          = (cnt_reg == 2'd0) || (pop && (idx_reg == cnt_reg - 2'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= res.cnt;
            idx_reg <= 2'd0;
        end
        else if (pop)
        begin
            if (idx_reg == cnt_reg - 2'd1)
            begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= res.rec;
        end
    end

endmodule

`default_nettype wire
